// ===== hdl/raycast_floor_texcoord_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the floor texture coordinate unit
// Clocked, reset-gated wrappers around concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_FLOOR_TEXCOORD_UNIT_MACROS_SVH
`define RAYCAST_FLOOR_TEXCOORD_UNIT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define RFC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define RFC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rfc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared widths, register codes and the sideband record that travels with
// each item down the floor texture coordinate pipeline.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int FracBits  = 16;
  localparam int RowW      = 10;
  localparam int HeightW   = 11;
  localparam int CoordW    = 23;   // wall point, Q7.16
  localparam int PosW      = 22;   // player position, Q6.16
  localparam int WdistW    = 24;
  localparam int DistW     = 27;   // (h << 16) / den
  localparam int WeightW   = 17;   // Q1.16, at most 1.0
  localparam int TexW      = 10;
  localparam int TexIdxW   = 16;   // cur*size >> 18
  localparam int AddrW     = 4;
  localparam int DataW     = 32;
  localparam int DistStages   = DistW;
  localparam int WeightStages = WeightW;

  localparam logic [WeightW-1:0] WeightOne = WeightW'(1) << FracBits;

  // Register index codes (byte address / 4)
  localparam logic [1:0] RegScreenHeight = 2'd0;
  localparam logic [1:0] RegTexWidth     = 2'd1;
  localparam logic [1:0] RegTexHeight    = 2'd2;

  localparam logic [HeightW-1:0] ScreenHeightRst = 11'd480;
  localparam logic [HeightW-1:0] TexWidthRst     = 11'd64;
  localparam logic [HeightW-1:0] TexHeightRst    = 11'd64;

  typedef struct packed {
    logic [RowW-1:0]    row;
    logic [HeightW-1:0] ceil;
    logic               vis;
    logic [CoordW-1:0]  wx;
    logic [CoordW-1:0]  wy;
    logic [PosW-1:0]    px;
    logic [PosW-1:0]    py;
    logic [WdistW-1:0]  wdist;
    logic               skip;    // weight forced to 1.0
  } rfc_side_t;

endpackage

// ===== hdl/rfc_in_if.sv =====
// ----------------------------------------------------------------------------
// rfc_in_if
// Input item channel: one column wall hit plus the row being shaded.
// ----------------------------------------------------------------------------
interface rfc_in_if;
  logic              valid;
  logic              ready;
  logic              side;
  logic signed [1:0] ray_x_sign;
  logic signed [1:0] ray_y_sign;
  logic [5:0]        cell_x;
  logic [5:0]        cell_y;
  logic [15:0]       wall_frac;
  logic [23:0]       wall_dist;
  logic [21:0]       player_x;
  logic [21:0]       player_y;
  logic [9:0]        screen_row;
  logic signed [10:0] wall_bottom;

  modport source (output valid, side, ray_x_sign, ray_y_sign, cell_x, cell_y, wall_frac,
                  wall_dist, player_x, player_y, screen_row, wall_bottom, input ready);
  modport sink   (input valid, side, ray_x_sign, ray_y_sign, cell_x, cell_y, wall_frac,
                  wall_dist, player_x, player_y, screen_row, wall_bottom, output ready);
endinterface

// ===== hdl/rfc_out_if.sv =====
// ----------------------------------------------------------------------------
// rfc_out_if
// Result item channel: texel coordinates and row information.
// ----------------------------------------------------------------------------
interface rfc_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  floor_row;
  logic [10:0] ceiling_row;
  logic [9:0]  tex_x;
  logic [9:0]  tex_y;
  logic        visible;

  modport source (output valid, floor_row, ceiling_row, tex_x, tex_y, visible, input ready);
  modport sink   (input valid, floor_row, ceiling_row, tex_x, tex_y, visible, output ready);
endinterface

// ===== hdl/raycast_floor_texcoord_unit.sv =====
// Pipeline: 49 register stages (1 entry, 27 distance divider, 17 weight divider,
// 4 interpolate/wrap). Throughput: one item per cycle while results are taken;
// the divider depth sets the latency.
// The whole pipeline advances together and holds while a result is not taken.
// Reset (rst_n low, synchronous) clears all valid bits and loads the registers
// with screen_height 480, tex_width 64, tex_height 64.
// ----------------------------------------------------------------------------
// raycast_floor_texcoord_unit
// Floor casting: texel coordinates, ceiling row and visibility for one pixel.
// ----------------------------------------------------------------------------
module raycast_floor_texcoord_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  rfc_in_if.sink                    in_chan,
  rfc_out_if.source                 out_chan,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rfc_pkg::AddrW-1:0] paddr,
  input  logic [rfc_pkg::DataW-1:0] pwdata,
  output logic [rfc_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  logic [rfc_pkg::HeightW-1:0] scr_h_r, tex_w_r, tex_h_r;
  logic                        en;
  logic                        cfg_wr;
  logic [1:0]                  reg_idx;

  logic                        v_f, v_d, v_w;
  rfc_pkg::rfc_side_t          side_f, side_d, side_w;
  logic [rfc_pkg::HeightW-1:0] den_f;
  logic [rfc_pkg::DistW-1:0]   dist_d;
  logic [rfc_pkg::WeightW-1:0] weight_w;

  // Register file
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_h_r <= rfc_pkg::ScreenHeightRst;
      tex_w_r <= rfc_pkg::TexWidthRst;
      tex_h_r <= rfc_pkg::TexHeightRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rfc_pkg::RegScreenHeight: scr_h_r <= pwdata[rfc_pkg::HeightW-1:0];
        rfc_pkg::RegTexWidth:     tex_w_r <= pwdata[rfc_pkg::HeightW-1:0];
        rfc_pkg::RegTexHeight:    tex_h_r <= pwdata[rfc_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rfc_pkg::RegScreenHeight: prdata = {{(rfc_pkg::DataW-rfc_pkg::HeightW){1'b0}}, scr_h_r};
      rfc_pkg::RegTexWidth:     prdata = {{(rfc_pkg::DataW-rfc_pkg::HeightW){1'b0}}, tex_w_r};
      rfc_pkg::RegTexHeight:    prdata = {{(rfc_pkg::DataW-rfc_pkg::HeightW){1'b0}}, tex_h_r};
      default:                  prdata = '0;
    endcase
  end

  // Pipeline advance: free output slot or result taken
  assign en            = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = en;

  rfc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_chan  (in_chan),
    .scr_h    (scr_h_r),
    .v_out    (v_f),
    .side_out (side_f),
    .den_out  (den_f)
  );

  rfc_dist_div u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .scr_h    (scr_h_r),
    .v_in     (v_f),
    .side_in  (side_f),
    .den_in   (den_f),
    .v_out    (v_d),
    .side_out (side_d),
    .dist_out (dist_d)
  );

  rfc_weight_div u_weight (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .v_in       (v_d),
    .side_in    (side_d),
    .dist_in    (dist_d),
    .v_out      (v_w),
    .side_out   (side_w),
    .weight_out (weight_w)
  );

  rfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tex_w     (tex_w_r),
    .tex_h     (tex_h_r),
    .v_in      (v_w),
    .side_in   (side_w),
    .weight_in (weight_w),
    .out_chan  (out_chan)
  );

endmodule

// ===== hdl/rfc_front.sv =====
// ----------------------------------------------------------------------------
// rfc_front
// Entry stage: wall foot point, horizon test, divisor, ceiling row and
// visibility flag, registered.
// ----------------------------------------------------------------------------
module rfc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  rfc_in_if.sink                      in_chan,
  input  logic [rfc_pkg::HeightW-1:0] scr_h,
  output logic                        v_out,
  output rfc_pkg::rfc_side_t          side_out,
  output logic [rfc_pkg::HeightW-1:0] den_out
);

  logic                        v_r;
  rfc_pkg::rfc_side_t          side_r, side_nxt;
  logic [rfc_pkg::HeightW-1:0] den_r, den_nxt;

  logic                        rx_pos, rx_neg, ry_pos;
  logic [6:0]                  cx1, cy1;
  logic [rfc_pkg::HeightW-1:0] two_row, row_ext, bottom, diff;
  logic                        horizon;

  // Wall point and per-row flags
  always_comb begin
    rx_pos  = (in_chan.ray_x_sign == 2'sb01);
    rx_neg  = in_chan.ray_x_sign[1];
    ry_pos  = (in_chan.ray_y_sign == 2'sb01);
    cx1     = {1'b0, in_chan.cell_x} + 7'd1;
    cy1     = {1'b0, in_chan.cell_y} + 7'd1;
    row_ext = {1'b0, in_chan.screen_row};
    two_row = {in_chan.screen_row, 1'b0};
    horizon = (two_row <= scr_h);
    diff    = two_row - scr_h;
    bottom  = in_chan.wall_bottom[10] ? scr_h : in_chan.wall_bottom;

    side_nxt.row   = in_chan.screen_row;
    side_nxt.ceil  = (row_ext <= scr_h) ? (scr_h - row_ext) : '0;
    side_nxt.vis   = (row_ext > bottom) && (row_ext < scr_h);
    side_nxt.px    = in_chan.player_x;
    side_nxt.py    = in_chan.player_y;
    side_nxt.wdist = in_chan.wall_dist;
    side_nxt.skip  = horizon || (in_chan.wall_dist == '0);

    if (!in_chan.side && rx_pos) begin
      side_nxt.wx = {1'b0, in_chan.cell_x, 16'b0};
      side_nxt.wy = {1'b0, in_chan.cell_y, in_chan.wall_frac};
    end else if (!in_chan.side && rx_neg) begin
      side_nxt.wx = {cx1, 16'b0};
      side_nxt.wy = {1'b0, in_chan.cell_y, in_chan.wall_frac};
    end else if (in_chan.side && ry_pos) begin
      side_nxt.wx = {1'b0, in_chan.cell_x, in_chan.wall_frac};
      side_nxt.wy = {1'b0, in_chan.cell_y, 16'b0};
    end else begin
      side_nxt.wx = {1'b0, in_chan.cell_x, in_chan.wall_frac};
      side_nxt.wy = {cy1, 16'b0};
    end

    // dummy divisor of one above the horizon
    den_nxt = horizon ? rfc_pkg::HeightW'(1) : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_chan.valid;
    end
    if (en) begin
      side_r <= side_nxt;
      den_r  <= den_nxt;
    end
  end

  assign v_out    = v_r;
  assign side_out = side_r;
  assign den_out  = den_r;

endmodule

// ===== hdl/rfc_dist_div.sv =====
// ----------------------------------------------------------------------------
// rfc_dist_div
// Pipelined restoring divider for the floor distance (h << 16) / den,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module rfc_dist_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [rfc_pkg::HeightW-1:0] scr_h,
  input  logic                        v_in,
  input  rfc_pkg::rfc_side_t          side_in,
  input  logic [rfc_pkg::HeightW-1:0] den_in,
  output logic                        v_out,
  output rfc_pkg::rfc_side_t          side_out,
  output logic [rfc_pkg::DistW-1:0]   dist_out
);

  localparam int N = rfc_pkg::DistStages;

  logic                        v_r    [N];
  rfc_pkg::rfc_side_t          side_r [N];
  logic [rfc_pkg::HeightW-1:0] den_r  [N];
  logic [rfc_pkg::HeightW-1:0] rem_r  [N];
  logic [rfc_pkg::DistW-1:0]   quo_r  [N];
  logic [rfc_pkg::HeightW-1:0] rem_nxt [N];
  logic [rfc_pkg::DistW-1:0]   quo_nxt [N];

  logic [rfc_pkg::DistW-1:0]   num;

  assign num = {scr_h, {rfc_pkg::FracBits{1'b0}}};

  // One restoring step per stage, most significant quotient bit first
  always_comb begin
    logic [rfc_pkg::HeightW-1:0] rp, dp;
    logic [rfc_pkg::DistW-1:0]   qp;
    logic [rfc_pkg::HeightW:0]   trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rp = '0;
        qp = '0;
        dp = den_in;
      end else begin
        rp = rem_r[k-1];
        qp = quo_r[k-1];
        dp = den_r[k-1];
      end
      trial = {rp, num[N-1-k]};
      quo_nxt[k] = qp;
      if (trial >= {1'b0, dp}) begin
        rem_nxt[k]       = rfc_pkg::HeightW'(trial - {1'b0, dp});
        quo_nxt[k][N-1-k] = 1'b1;
      end else begin
        rem_nxt[k] = trial[rfc_pkg::HeightW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int k = 1; k < N; k++) v_r[k] <= v_r[k-1];
    end
    if (en) begin
      side_r[0] <= side_in;
      den_r[0]  <= den_in;
      for (int k = 1; k < N; k++) begin
        side_r[k] <= side_r[k-1];
        den_r[k]  <= den_r[k-1];
      end
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  assign v_out    = v_r[N-1];
  assign side_out = side_r[N-1];
  assign dist_out = quo_r[N-1];

endmodule

// ===== hdl/rfc_weight_div.sv =====
// ----------------------------------------------------------------------------
// rfc_weight_div
// Pipelined restoring divider for the weight (dist << 16) / wall_dist,
// saturated to 1.0. Quotients of two or more are caught on entry.
// ----------------------------------------------------------------------------
module rfc_weight_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        v_in,
  input  rfc_pkg::rfc_side_t          side_in,
  input  logic [rfc_pkg::DistW-1:0]   dist_in,
  output logic                        v_out,
  output rfc_pkg::rfc_side_t          side_out,
  output logic [rfc_pkg::WeightW-1:0] weight_out
);

  localparam int N = rfc_pkg::WeightStages;
  localparam int W = rfc_pkg::WdistW;

  logic                        v_r    [N];
  rfc_pkg::rfc_side_t          side_r [N];
  logic                        sat_r  [N];
  logic [W-1:0]                rem_r  [N];
  logic [N-1:0]                quo_r  [N];
  logic [W-1:0]                rem_nxt [N];
  logic [N-1:0]                quo_nxt [N];
  logic                        sat_in;
  logic [W-1:0]                rem_in;

  // Saturate when skipped or when the quotient would reach 2.0
  always_comb begin
    sat_in = side_in.skip ||
             (dist_in >= {{(rfc_pkg::DistW-W-1){1'b0}}, side_in.wdist, 1'b0});
    rem_in = sat_in ? '0 : dist_in[W:1];
  end

  always_comb begin
    logic [W-1:0] rp, dp;
    logic [N-1:0] qp;
    logic         nb;
    logic [W:0]   trial;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rp = rem_in;
        qp = '0;
        dp = side_in.wdist;
        nb = dist_in[0];
      end else begin
        rp = rem_r[k-1];
        qp = quo_r[k-1];
        dp = side_r[k-1].wdist;
        nb = 1'b0;
      end
      trial = {rp, nb};
      quo_nxt[k] = qp;
      if (trial >= {1'b0, dp}) begin
        rem_nxt[k]        = W'(trial - {1'b0, dp});
        quo_nxt[k][N-1-k] = 1'b1;
      end else begin
        rem_nxt[k] = trial[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= v_in;
      for (int k = 1; k < N; k++) v_r[k] <= v_r[k-1];
    end
    if (en) begin
      side_r[0] <= side_in;
      sat_r[0]  <= sat_in;
      for (int k = 1; k < N; k++) begin
        side_r[k] <= side_r[k-1];
        sat_r[k]  <= sat_r[k-1];
      end
      for (int k = 0; k < N; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
      end
    end
  end

  // Clamp to 1.0
  assign weight_out = (sat_r[N-1] || (quo_r[N-1] > rfc_pkg::WeightOne)) ?
                      rfc_pkg::WeightOne : quo_r[N-1];
  assign v_out      = v_r[N-1];
  assign side_out   = side_r[N-1];

endmodule

// ===== hdl/rfc_back.sv =====
// ----------------------------------------------------------------------------
// rfc_back
// Interpolation between player and wall point, texture scaling and wrap.
// Four stages: products, sum, scale, wrap (output register).
// ----------------------------------------------------------------------------
module rfc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [rfc_pkg::HeightW-1:0] tex_w,
  input  logic [rfc_pkg::HeightW-1:0] tex_h,
  input  logic                        v_in,
  input  rfc_pkg::rfc_side_t          side_in,
  input  logic [rfc_pkg::WeightW-1:0] weight_in,
  rfc_out_if.source                   out_chan
);

  localparam int PW = rfc_pkg::CoordW + rfc_pkg::WeightW;   // 40

  logic [rfc_pkg::WeightW-1:0] inv_w;

  // stage 1: products
  logic                        v1_r;
  rfc_pkg::rfc_side_t          s1_r;
  logic [PW-1:0]               axw_r, axp_r, ayw_r, ayp_r;
  // stage 2: interpolated coordinates
  logic                        v2_r;
  rfc_pkg::rfc_side_t          s2_r;
  logic [rfc_pkg::CoordW-1:0]  curx_r, cury_r;
  logic [PW-1:0]               sumx, sumy;
  // stage 3: scaled texel index before wrap
  logic                        v3_r;
  logic [rfc_pkg::RowW-1:0]    row3_r;
  logic [rfc_pkg::HeightW-1:0] ceil3_r;
  logic                        vis3_r;
  logic [rfc_pkg::CoordW+rfc_pkg::HeightW-1:0] prodx, prody;
  logic [rfc_pkg::TexIdxW-1:0] tx_r, ty_r;
  // stage 4: wrap
  logic                        v4_r;
  logic [rfc_pkg::RowW-1:0]    row4_r;
  logic [rfc_pkg::HeightW-1:0] ceil4_r;
  logic                        vis4_r;
  logic [rfc_pkg::TexW-1:0]    texx_r, texy_r;

  function automatic logic [rfc_pkg::TexW-1:0] wrap(
    input logic [rfc_pkg::TexIdxW-1:0] t,
    input logic [rfc_pkg::HeightW-1:0] size
  );
    logic [rfc_pkg::TexIdxW-1:0] r;
    logic [rfc_pkg::TexIdxW+4:0] sh;
    r = t;
    // index is below 32 * size, so five conditional subtracts finish the remainder
    for (int b = 4; b >= 0; b--) begin
      sh = {10'b0, size} << b;
      if ({5'b0, r} >= sh) r = rfc_pkg::TexIdxW'({5'b0, r} - sh);
    end
    return (size == '0) ? '0 : r[rfc_pkg::TexW-1:0];
  endfunction

  assign inv_w = rfc_pkg::WeightOne - weight_in;
  assign sumx  = axw_r + axp_r;
  assign sumy  = ayw_r + ayp_r;
  assign prodx = {{rfc_pkg::HeightW{1'b0}}, curx_r} * {{rfc_pkg::CoordW{1'b0}}, tex_w};
  assign prody = {{rfc_pkg::HeightW{1'b0}}, cury_r} * {{rfc_pkg::CoordW{1'b0}}, tex_h};

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= side_in;
      axw_r <= {{rfc_pkg::CoordW{1'b0}}, weight_in} * {{rfc_pkg::WeightW{1'b0}}, side_in.wx};
      axp_r <= {{rfc_pkg::CoordW{1'b0}}, inv_w} *
               {{(rfc_pkg::WeightW+1){1'b0}}, side_in.px};
      ayw_r <= {{rfc_pkg::CoordW{1'b0}}, weight_in} * {{rfc_pkg::WeightW{1'b0}}, side_in.wy};
      ayp_r <= {{rfc_pkg::CoordW{1'b0}}, inv_w} *
               {{(rfc_pkg::WeightW+1){1'b0}}, side_in.py};

      s2_r   <= s1_r;
      curx_r <= sumx[rfc_pkg::FracBits+rfc_pkg::CoordW-1:rfc_pkg::FracBits];
      cury_r <= sumy[rfc_pkg::FracBits+rfc_pkg::CoordW-1:rfc_pkg::FracBits];

      row3_r  <= s2_r.row;
      ceil3_r <= s2_r.ceil;
      vis3_r  <= s2_r.vis;
      tx_r    <= prodx[rfc_pkg::FracBits+2+rfc_pkg::TexIdxW-1:rfc_pkg::FracBits+2];
      ty_r    <= prody[rfc_pkg::FracBits+2+rfc_pkg::TexIdxW-1:rfc_pkg::FracBits+2];

      row4_r  <= row3_r;
      ceil4_r <= ceil3_r;
      vis4_r  <= vis3_r;
      texx_r  <= wrap(tx_r, tex_w);
      texy_r  <= wrap(ty_r, tex_h);
    end
  end

  assign out_chan.valid       = v4_r;
  assign out_chan.floor_row   = row4_r;
  assign out_chan.ceiling_row = ceil4_r;
  assign out_chan.tex_x       = texx_r;
  assign out_chan.tex_y       = texy_r;
  assign out_chan.visible     = vis4_r;

endmodule

// ===== hdl/rfc_checker.sv =====
// ----------------------------------------------------------------------------
// rfc_checker
// Port-level checks on the floor texture coordinate unit, bound to the top.
// ----------------------------------------------------------------------------
`include "raycast_floor_texcoord_unit_macros.svh"

module rfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_visible,
  input logic [10:0] out_ceiling_row,
  input logic        pready
);

  // a result that is not taken stays offered
  `RFC_ASSERT_ALWAYS(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")

  // input is taken whenever the output slot frees up
  `RFC_ASSERT_ALWAYS(a_in_ready, clk, rst_n, in_ready == (!out_valid || out_ready), "ready mismatch")

  // a visible row lies above the screen bottom, so its mirrored row is nonzero
  `RFC_ASSERT_IMPLIES(a_vis_ceil, clk, rst_n, out_valid && out_visible, out_ceiling_row != '0, "zero ceiling")

  // nothing comes out in the cycle after reset
  `RFC_ASSERT_IMPLIES(a_rst_empty, clk, rst_n, $past(!rst_n), !out_valid, "result after reset")

  `RFC_ASSERT_ALWAYS(a_pready, clk, rst_n, pready, "config port not ready")

endmodule

bind raycast_floor_texcoord_unit rfc_checker u_rfc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_visible     (out_chan.visible),
  .out_ceiling_row (out_chan.ceiling_row),
  .pready          (pready)
);
